// ===== rtl/escape_sequence_key_decoder_core_defines.svh =====
// assertion macros used by the decoder core rtl
`ifndef ESCAPE_SEQUENCE_KEY_DECODER_CORE_DEFINES_SVH
`define ESCAPE_SEQUENCE_KEY_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ESCKD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("esckd check failed");

// next-cycle implication, checked outside reset
`define ESCKD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("esckd check failed");

`endif

// ===== rtl/esckd_pkg.sv =====
`timescale 1ns / 1ps

package esckd_pkg;

   // table geometry
   localparam int KEY_COUNT = 25;
   localparam int SEQ_DEPTH = 5;
   localparam int KEY_IDX_W = $clog2(KEY_COUNT);
   localparam int COUNT_W   = $clog2(SEQ_DEPTH + 1);

   localparam logic [7:0] ESC_BYTE = 8'h1B;

   // result kinds
   localparam logic [1:0] KIND_PENDING = 2'd0;
   localparam logic [1:0] KIND_PLAIN   = 2'd1;
   localparam logic [1:0] KIND_KEY     = 2'd2;

   typedef logic [7:0] byte_type;
   typedef byte_type key_seq_type [SEQ_DEPTH];

   // key sequences after the escape byte, in key index order
   localparam key_seq_type KEY_BYTES [KEY_COUNT] = '{
      '{"[", "2", "~", 8'h00, 8'h00},
      '{"[", "3", "~", 8'h00, 8'h00},
      '{"O", "H", 8'h00, 8'h00, 8'h00},
      '{"O", "F", 8'h00, 8'h00, 8'h00},
      '{"[", "5", "~", 8'h00, 8'h00},
      '{"[", "6", "~", 8'h00, 8'h00},
      '{"[", "D", 8'h00, 8'h00, 8'h00},
      '{"[", "C", 8'h00, 8'h00, 8'h00},
      '{"[", "A", 8'h00, 8'h00, 8'h00},
      '{"[", "B", 8'h00, 8'h00, 8'h00},
      '{"[", "1", ";", "5", "D"},
      '{"[", "1", ";", "5", "C"},
      '{"[", "1", ";", "5", "A"},
      '{"[", "1", ";", "5", "B"},
      '{"[", "1", ";", "2", "D"},
      '{"[", "1", ";", "2", "C"},
      '{"[", "1", ";", "2", "A"},
      '{"[", "1", ";", "2", "B"},
      '{"[", "1", ";", "3", "D"},
      '{"[", "1", ";", "3", "C"},
      '{"[", "1", ";", "3", "A"},
      '{"[", "1", ";", "3", "B"},
      '{"[", "Z", 8'h00, 8'h00, 8'h00},
      '{"p", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [COUNT_W-1:0] KEY_LEN [KEY_COUNT] = '{
      3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd5, 3'd5, 3'd2, 3'd1, 3'd1
   };

   // sequence tracking state: candidate mask holds keys still matching
   typedef struct packed {
      logic                 in_seq;
      logic [COUNT_W-1:0]   count;
      logic [KEY_COUNT-1:0] cand;
   } seq_state_type;

   typedef struct packed {
      logic [1:0] kind;
      byte_type   value;
   } result_type;

endpackage

// ===== rtl/esckd_step.sv =====
`timescale 1ns / 1ps

module esckd_step import esckd_pkg::*; (
   input  byte_type      in_byte,
   input  seq_state_type state,
   output result_type    result,
   output seq_state_type state_in
);

   logic [KEY_COUNT-1:0] hit;
   logic [KEY_IDX_W-1:0] sel;
   logic [COUNT_W-1:0]   count_inc;
   logic                 room;

   assign room      = state.count < COUNT_W'(SEQ_DEPTH);
   assign count_inc = state.count + 1'b1;

   // compare the new byte against every candidate at the current position
   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         hit[k] = room && state.cand[k] && (KEY_LEN[k] > state.count)
                  && (KEY_BYTES[k][state.count] == in_byte);
      end
   end

   // lowest matching key wins
   always_comb begin
      sel = '0;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (hit[k]) begin
            sel = KEY_IDX_W'(k);
         end
      end
   end

   // result and next sequence state
   always_comb begin
      result   = '{kind: KIND_PLAIN, value: in_byte};
      state_in = '{in_seq: 1'b0, count: '0, cand: '0};
      if (!state.in_seq) begin
         if (in_byte == ESC_BYTE) begin
            result   = '{kind: KIND_PENDING, value: 8'h00};
            state_in = '{in_seq: 1'b1, count: '0, cand: '1};
         end
      end else if (|hit) begin
         if (KEY_LEN[sel] == count_inc) begin
            result = '{kind: KIND_KEY, value: 8'(sel)};
         end else begin
            result   = '{kind: KIND_PENDING, value: 8'h00};
            state_in = '{in_seq: 1'b1, count: count_inc, cand: hit};
         end
      end
   end

endmodule

// ===== rtl/escape_sequence_key_decoder_core.sv =====
`timescale 1ns / 1ps

// channel   dir  tdata                 tuser
// req_      in   [7:0] in_byte         -
// rsp_      out  [7:0] result_value    [1:0] result_kind
//
// one request accepted per cycle while the response is not stalled, one response per request
// a request passes the input register, then the response register;
// the escape table compare is a single combinational pass between the
// input register and the response register
// reset clears the sequence state and both valid flags
// a stalled response holds the input stage; req_tready drops only then

`include "escape_sequence_key_decoder_core_defines.svh"

module escape_sequence_key_decoder_core import esckd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] result_value
   output logic [1:0] rsp_tuser    // [1:0] result_kind
);

   logic          s1_valid_ff;
   byte_type      s1_byte_ff;
   logic          s1_adv;
   seq_state_type state_ff;
   seq_state_type state_in;
   result_type    step_rsp;
   logic          rsp_valid_ff;
   result_type    rsp_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   esckd_step u_step (
      .in_byte  (s1_byte_ff),
      .state    (state_ff),
      .result   (step_rsp),
      .state_in (state_in)
   );

   // control: valid flags and sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
      if (s1_adv) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.kind;

   // outside a sequence the count stays cleared
   `ESCKD_ASSERT_NOW(a_idle_count, !state_ff.in_seq, state_ff.count == '0)
   // a recognised key always closes the sequence
   `ESCKD_ASSERT_NEXT(a_key_closes, s1_adv && step_rsp.kind == KIND_KEY, !state_ff.in_seq)
   // key responses carry a table index, pending ones carry zero
   `ESCKD_ASSERT_NOW(a_key_range, rsp_tvalid && rsp_tuser == KIND_KEY, rsp_tdata < KEY_COUNT)
   `ESCKD_ASSERT_NOW(a_pend_zero, rsp_tvalid && rsp_tuser == KIND_PENDING, rsp_tdata == 8'h00)
   // an empty response register never blocks a request
   `ESCKD_ASSERT_NOW(a_no_block, !rsp_valid_ff, req_tready)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import esckd_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 1400;
   localparam int QUIET_TAIL = 150;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [7:0] data;
      bit         hold;   // wait until every decode has come back before sending
   } term_byte_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   term_byte_type terminal_bytes[$];
   result_type expected_decodes[$];

   // predictor state
   bit         esc_open = 1'b0;
   int         esc_count = 0;
   logic [7:0] esc_buf [SEQ_DEPTH];

   bit  hold_next = 1'b0;
   bit  stim_done = 1'b0;
   bit  req_fire = 1'b0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   int  req_idle_pct = 20;
   int  rsp_idle_pct = 20;
   int  sent_count = 0;
   int  accepted_count = 0;
   int  queued_total = 0;
   int  mismatch_count = 0;
   int  cycle_count = 0;

   escape_sequence_key_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // key strings after the escape byte, first character in the highest used byte
   function automatic logic [39:0] key_text(input int idx);
      case (idx)
         0:  return "[2~";
         1:  return "[3~";
         2:  return "OH";
         3:  return "OF";
         4:  return "[5~";
         5:  return "[6~";
         6:  return "[D";
         7:  return "[C";
         8:  return "[A";
         9:  return "[B";
         10: return "[1;5D";
         11: return "[1;5C";
         12: return "[1;5A";
         13: return "[1;5B";
         14: return "[1;2D";
         15: return "[1;2C";
         16: return "[1;2A";
         17: return "[1;2B";
         18: return "[1;3D";
         19: return "[1;3C";
         20: return "[1;3A";
         21: return "[1;3B";
         22: return "[Z";
         23: return "p";
         24: return "n";
         default: return '0;
      endcase
   endfunction

   // no key holds a zero byte, so the length is the count of non-zero bytes
   function automatic int key_length(input logic [39:0] text);
      int n;
      n = 0;
      for (int i = 0; i < SEQ_DEPTH; i++)
         if (text[8*i +: 8] != 8'h00) n++;
      return n;
   endfunction

   function automatic logic [7:0] key_byte(input logic [39:0] text, input int len, input int pos);
      return text[8*(len-1-pos) +: 8];
   endfunction

   // decode one terminal byte against the key table, updating the sequence state
   function automatic result_type decode_byte(input logic [7:0] b);
      result_type r;
      logic [39:0] text;
      int len;
      bit hit;
      r.kind = KIND_PLAIN;
      r.value = b;
      if (!esc_open) begin
         if (b == ESC_BYTE) begin
            esc_open = 1'b1;
            esc_count = 0;
            r.kind = KIND_PENDING;
            r.value = 8'h00;
         end
         return r;
      end
      if (esc_count < SEQ_DEPTH) begin
         esc_buf[esc_count] = b;
         esc_count++;
         for (int k = 0; k < KEY_COUNT; k++) begin
            text = key_text(k);
            len = key_length(text);
            hit = (len >= esc_count);
            for (int i = 0; i < esc_count && hit; i++)
               if (key_byte(text, len, i) != esc_buf[i]) hit = 1'b0;
            if (hit) begin
               if (len == esc_count) begin
                  esc_open = 1'b0;
                  esc_count = 0;
                  r.kind = KIND_KEY;
                  r.value = 8'(k);
               end else begin
                  r.kind = KIND_PENDING;
                  r.value = 8'h00;
               end
               return r;
            end
         end
      end
      // mismatch: buffered bytes dropped, current byte passes through
      esc_open = 1'b0;
      esc_count = 0;
      return r;
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      term_byte_type item;
      item.data = b;
      item.hold = hold_next;
      hold_next = 1'b0;
      terminal_bytes.push_back(item);
   endtask

   task automatic queue_key(input int k);
      logic [39:0] text;
      int len;
      text = key_text(k);
      len = key_length(text);
      queue_byte(ESC_BYTE);
      for (int i = 0; i < len; i++) queue_byte(key_byte(text, len, i));
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // reset held from the start, then released on a falling clock edge
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // stimulus: directed sequences first, then mostly well-formed random keys
   initial begin : stimulus
      int pick;
      int k;
      int len;
      int cut;
      logic [39:0] text;
      logic [39:0] other;

      // extremes of plain bytes
      queue_byte(8'h00);
      queue_byte(8'hFF);
      // three, one and five byte keys
      queue_key(0);
      queue_key(23);
      queue_key(10);
      // escape inside a sequence comes out plain
      queue_byte(ESC_BYTE);
      queue_byte(ESC_BYTE);
      // zero byte inside a sequence
      queue_byte(ESC_BYTE);
      queue_byte(8'h00);
      // mismatch after a partial match drops the buffered bytes
      queue_byte(ESC_BYTE);
      queue_byte("[");
      queue_byte("1");
      queue_byte("x");
      queue_key(3);

      // every key once, after a full drain
      hold_next = 1'b1;
      for (int i = 0; i < KEY_COUNT; i++) queue_key(i);

      while (terminal_bytes.size() < 25 + RANDOM_BYTES) begin
         if ($urandom_range(99) == 0) hold_next = 1'b1;
         pick = $urandom_range(99);
         if (pick < 55) begin
            queue_key($urandom_range(KEY_COUNT - 1));
         end else if (pick < 70) begin
            // broken sequence: a proper prefix, then a near miss or a random byte
            k = $urandom_range(KEY_COUNT - 1);
            text = key_text(k);
            len = key_length(text);
            cut = $urandom_range(len - 1, 0);
            queue_byte(ESC_BYTE);
            for (int i = 0; i < cut; i++) queue_byte(key_byte(text, len, i));
            if ($urandom_range(1) == 0) begin
               queue_byte(8'($urandom));
            end else begin
               other = key_text($urandom_range(KEY_COUNT - 1));
               len = key_length(other);
               queue_byte(key_byte(other, len, $urandom_range(len - 1)));
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(4, 1)) queue_byte(8'($urandom));
         end else if (pick < 95) begin
            queue_byte(ESC_BYTE);
            queue_byte(8'($urandom));
         end else begin
            queue_byte(ESC_BYTE);
            queue_byte(ESC_BYTE);
         end
      end
      queued_total = terminal_bytes.size();
      stim_done = 1'b1;

      // wait for every request and its decode, then let the pipeline settle
      while (accepted_count < queued_total || expected_decodes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // timeout
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_top: done, errors");
      $finish;
   end

   // request driver, fed from the byte queue
   always @(negedge clock) begin : driver
      logic next_valid;
      logic [7:0] next_data;
      bit quiet;
      term_byte_type item;
      next_valid = req_tvalid;
      next_data = req_tdata;
      quiet = stim_done && terminal_bytes.size() < QUIET_TAIL;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_fire) begin
         next_valid = 1'b0;
         next_data = 8'($urandom);
         if (req_gap > 0) begin
            req_gap--;
         end else if (terminal_bytes.size() != 0) begin
            if (terminal_bytes[0].hold && expected_decodes.size() != 0) begin
               // hold off until the decoder has drained
            end else if (!quiet && $urandom_range(99) < req_idle_pct) begin
               req_gap = $urandom_range(12, 0);
            end else begin
               item = terminal_bytes.pop_front();
               next_valid = 1'b1;
               next_data = item.data;
               sent_count++;
               // change how busy both sides are every so often
               if (sent_count % 64 == 0) begin
                  case ($urandom_range(2))
                     0: req_idle_pct = 0;
                     1: req_idle_pct = 10;
                     default: req_idle_pct = 30;
                  endcase
                  case ($urandom_range(2))
                     0: rsp_idle_pct = 0;
                     1: rsp_idle_pct = 10;
                     default: rsp_idle_pct = 30;
                  endcase
               end
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
   end

   // response back-pressure
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else if (!(stim_done && terminal_bytes.size() < QUIET_TAIL)
                   && $urandom_range(99) < rsp_idle_pct) begin
         rsp_tready <= 1'b0;
         rsp_stall = $urandom_range(12, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // accepted requests feed the predictor; responses are checked in order
   always @(posedge clock) begin : monitor
      result_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fire = 1'b1;
            accepted_count++;
            expected_decodes.push_back(decode_byte(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decodes.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with nothing expected, kind %0d value 0x%02h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_tuser !== want.kind) begin
                  mismatch_count++;
                  $display("%0t: result_kind expected %0d got %0d",
                           $time, want.kind, rsp_tuser);
               end
               if (rsp_tdata !== want.value) begin
                  mismatch_count++;
                  $display("%0t: result_value expected 0x%02h got 0x%02h",
                           $time, want.value, rsp_tdata);
               end
            end
         end
      end
   end

endmodule
